FILE: rtl/periodic_waveform_generator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic waveform generator
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_WAVEFORM_GENERATOR_ASSERT_SVH
`define PERIODIC_WAVEFORM_GENERATOR_ASSERT_SVH

// check on every clock edge outside reset
`define PWG_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check on every clock edge, reset included
`define PWG_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/pwg_pkg.sv
// ----------------------------------------------------------------------------
// Periodic waveform generator package
// Shared types, codes, constants and the sine table entry function.
// ----------------------------------------------------------------------------
package pwg_pkg;

	localparam int PHASE_W = 32;
	localparam int DIGIT_W = 8;
	localparam int N_CELLS = PHASE_W / DIGIT_W;
	localparam int AMP_W   = 15;
	localparam int SHAPE_W = 2;
	localparam int SAMPLE_W = 16;
	localparam int TRI_W   = 31;
	localparam int PROD_W  = AMP_W + TRI_W;

	localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd2;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	typedef enum logic [1:0] {
		REG_PHASE_STEP   = 2'd0,
		REG_PHASE_OFFSET = 2'd1,
		REG_AMPLITUDE    = 2'd2,
		REG_WAVE_SHAPE   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_step;
		logic [PHASE_W-1:0] phase_offset;
		logic [AMP_W-1:0]   amplitude;
		logic [SHAPE_W-1:0] wave_shape;
	} cfg_t;

	// sin(pi/2 * k / 2^tb) in unsigned Q0.15 through a Q30 Taylor series
	function automatic logic [AMP_W-1:0] sine_entry(int unsigned k, int unsigned tb);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] q15;
		logic signed [63:0] sum;
		int n;
		x = (HALF_PI_Q30 * 64'(k) + (64'd1 << (tb - 1))) >> tb;
		x2 = (x * x) >> 30;
		term = x;
		sum = signed'(x);
		for (n = 0; n < 8; n++) begin
			term = (term * x2) >> 30;
			term = term / TAYLOR_DIV[n];
			if (n[0] == 1'b0) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = 64'sd0;
		end
		q15 = (64'(sum) + 64'd16384) >> 15;
		if (q15 > 64'd32767) begin
			q15 = 64'd32767;
		end
		return q15[AMP_W-1:0];
	endfunction

endpackage

FILE: rtl/pwg_mac_cell.sv
// ----------------------------------------------------------------------------
// Phase multiply-accumulate cell
// Adds phase_step times one byte of the time stamp into the running phase
// and hands phase and time stamp to the next cell.
// ----------------------------------------------------------------------------
module pwg_mac_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [pwg_pkg::PHASE_W-1:0]  step,
	input  logic                         up_valid,
	output logic                         up_ready,
	input  logic [pwg_pkg::PHASE_W-1:0]  up_acc,
	input  logic [pwg_pkg::PHASE_W-1:0]  up_time,
	output logic                         dn_valid,
	input  logic                         dn_ready,
	output logic [pwg_pkg::PHASE_W-1:0]  dn_acc,
	output logic [pwg_pkg::PHASE_W-1:0]  dn_time
);

	localparam int SHIFT = CELL_IDX * pwg_pkg::DIGIT_W;
	localparam int MUL_W = pwg_pkg::PHASE_W + pwg_pkg::DIGIT_W;

	logic [pwg_pkg::DIGIT_W-1:0] digit;
	logic [MUL_W-1:0]            prod;
	logic [pwg_pkg::PHASE_W-1:0] part;
	logic                        valid_s1;
	logic [pwg_pkg::PHASE_W-1:0] acc_s1;
	logic [pwg_pkg::PHASE_W-1:0] time_s1;

	assign digit    = up_time[SHIFT +: pwg_pkg::DIGIT_W];
	assign prod     = MUL_W'(step) * MUL_W'(digit);
	assign part     = prod[pwg_pkg::PHASE_W-1:0] << SHIFT;
	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			acc_s1  <= up_acc + part;
			time_s1 <= up_time;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_acc   = acc_s1;
	assign dn_time  = time_s1;

endmodule

FILE: rtl/pwg_shaper.sv
// ----------------------------------------------------------------------------
// Waveform shaper
// Turns a phase into a scaled sine, square or triangle sample over three
// pipeline stages: table read and fold, amplitude multiply, round and sign.
// ----------------------------------------------------------------------------
module pwg_shaper #(
	parameter int TABLE_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pwg_pkg::cfg_t                  cfg,
	input  logic                           up_valid,
	output logic                           up_ready,
	input  logic [pwg_pkg::PHASE_W-1:0]    phase,
	output logic                           dn_valid,
	input  logic                           dn_stall,
	output logic signed [pwg_pkg::SAMPLE_W-1:0] dn_sample
);

	localparam int N     = 1 << TABLE_BITS;
	localparam int IDX_W = TABLE_BITS + 1;

	logic [pwg_pkg::AMP_W-1:0] rom [N+1];

	for (genvar k = 0; k <= N; k++) begin : g_rom
		assign rom[k] = pwg_pkg::sine_entry(k, TABLE_BITS);
	end

	logic                        rdy1, rdy2, rdy3;
	logic                        valid_s1, valid_s2, valid_s3;
	logic [TABLE_BITS-1:0]       tab_i;
	logic [IDX_W-1:0]            tab_idx;
	logic [pwg_pkg::TRI_W-1:0]   tri_mag;
	logic [pwg_pkg::AMP_W-1:0]   sin_s1;
	logic [pwg_pkg::TRI_W-1:0]   tri_s1;
	logic                        neg_s1;
	logic                        sq_pos_s1;
	logic                        is_sq_s1, is_tri_s1;
	logic [pwg_pkg::TRI_W-1:0]   mul_mag;
	logic [pwg_pkg::PROD_W-1:0]  prod_s2;
	logic                        neg_s2;
	logic                        is_sq_s2, is_tri_s2;
	logic [pwg_pkg::PROD_W-1:0]  rnd;
	logic [pwg_pkg::AMP_W-1:0]   mag;
	logic signed [pwg_pkg::SAMPLE_W-1:0] sample_s3;

	assign rdy3     = !valid_s3 || !dn_stall;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign up_ready = rdy1;

	assign tab_i   = phase[29 -: TABLE_BITS];
	assign tab_idx = phase[30] ? (IDX_W'(N) - {1'b0, tab_i}) : {1'b0, tab_i};

	always_comb begin
		unique case (phase[31:30])
			2'd0: tri_mag = phase[pwg_pkg::TRI_W-1:0];
			2'd1: tri_mag = pwg_pkg::TRI_W'(32'h8000_0000 - phase);
			2'd2: tri_mag = pwg_pkg::TRI_W'(phase - 32'h8000_0000);
			default: tri_mag = pwg_pkg::TRI_W'(32'd0 - phase);
		endcase
	end

	assign mul_mag = is_tri_s1 ? tri_s1 : pwg_pkg::TRI_W'(sin_s1);

	assign rnd = prod_s2 + (is_tri_s2 ? (pwg_pkg::PROD_W'(1) << 29)
	                                  : (pwg_pkg::PROD_W'(1) << 14));

	always_comb begin
		priority if (is_sq_s2) begin
			mag = cfg.amplitude;
		end else if (is_tri_s2) begin
			mag = rnd[30 +: pwg_pkg::AMP_W];
		end else begin
			mag = rnd[15 +: pwg_pkg::AMP_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= up_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && up_valid) begin
			sin_s1    <= rom[tab_idx];
			tri_s1    <= tri_mag;
			neg_s1    <= phase[31];
			sq_pos_s1 <= (phase != '0) && !phase[31];
			is_sq_s1  <= (cfg.wave_shape == pwg_pkg::SHAPE_SQUARE);
			is_tri_s1 <= (cfg.wave_shape == pwg_pkg::SHAPE_TRIANGLE);
		end
		if (rdy2 && valid_s1) begin
			prod_s2   <= pwg_pkg::PROD_W'(cfg.amplitude) * pwg_pkg::PROD_W'(mul_mag);
			neg_s2    <= is_sq_s1 ? !sq_pos_s1 : neg_s1;
			is_sq_s2  <= is_sq_s1;
			is_tri_s2 <= is_tri_s1;
		end
		if (rdy3 && valid_s2) begin
			sample_s3 <= neg_s2 ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
		end
	end

	assign dn_valid  = valid_s3;
	assign dn_sample = sample_s3;

endmodule

FILE: rtl/periodic_waveform_generator.sv
// ----------------------------------------------------------------------------
// Periodic waveform generator
// Computes one sine, square or triangle sample per time stamp.
//
// Time stamps enter on time_ticks with time_valid; a transfer happens on a
// clock edge with time_valid high and time_stall low. Each transfer yields
// exactly one transfer of sample, in order, with sample_valid/sample_stall.
// Phase is phase_step * time_ticks + phase_offset mod 2^32, built by a row
// of four byte-wide multiply-accumulate cells, followed by three shaper
// stages (quarter-wave table read, amplitude multiply, round and sign).
// Throughput is one sample per cycle while sample_stall is low.
// Registers are written through cfg_wr_en/cfg_index/cfg_data; the user must
// write them only while idle, which the block itself does not enforce.
// Reset clears the configuration registers to zero and empties the
// pipeline; the sine table is constant and needs no fill.
// A stall on the sample side holds the last stage; earlier stages keep
// filling until the pipeline is full, and only then is time_stall raised.
// ----------------------------------------------------------------------------
module periodic_waveform_generator #(
	parameter int TABLE_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [1:0]                          cfg_index,
	input  logic [pwg_pkg::PHASE_W-1:0]         cfg_data,
	input  logic                                time_valid,
	output logic                                time_stall,
	input  logic [pwg_pkg::PHASE_W-1:0]         time_ticks,
	output logic                                sample_valid,
	input  logic                                sample_stall,
	output logic signed [pwg_pkg::SAMPLE_W-1:0] sample
);

	pwg_pkg::cfg_t cfg_q;

	logic                        link_valid [pwg_pkg::N_CELLS+1];
	logic                        link_ready [pwg_pkg::N_CELLS+1];
	logic [pwg_pkg::PHASE_W-1:0] link_acc   [pwg_pkg::N_CELLS+1];
	logic [pwg_pkg::PHASE_W-1:0] link_time  [pwg_pkg::N_CELLS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (pwg_pkg::cfg_reg_t'(cfg_index))
				pwg_pkg::REG_PHASE_STEP:   cfg_q.phase_step   <= cfg_data;
				pwg_pkg::REG_PHASE_OFFSET: cfg_q.phase_offset <= cfg_data;
				pwg_pkg::REG_AMPLITUDE:    cfg_q.amplitude    <= cfg_data[pwg_pkg::AMP_W-1:0];
				pwg_pkg::REG_WAVE_SHAPE:   cfg_q.wave_shape   <= cfg_data[pwg_pkg::SHAPE_W-1:0];
			endcase
		end
	end

	assign link_valid[0] = time_valid;
	assign link_acc[0]   = cfg_q.phase_offset;
	assign link_time[0]  = time_ticks;
	assign time_stall    = !link_ready[0];

	for (genvar c = 0; c < pwg_pkg::N_CELLS; c++) begin : g_cell
		pwg_mac_cell #(
			.CELL_IDX (c)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (cfg_q.phase_step),
			.up_valid (link_valid[c]),
			.up_ready (link_ready[c]),
			.up_acc   (link_acc[c]),
			.up_time  (link_time[c]),
			.dn_valid (link_valid[c+1]),
			.dn_ready (link_ready[c+1]),
			.dn_acc   (link_acc[c+1]),
			.dn_time  (link_time[c+1])
		);
	end

	pwg_shaper #(
		.TABLE_BITS (TABLE_BITS)
	) u_shaper (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.up_valid  (link_valid[pwg_pkg::N_CELLS]),
		.up_ready  (link_ready[pwg_pkg::N_CELLS]),
		.phase     (link_acc[pwg_pkg::N_CELLS]),
		.dn_valid  (sample_valid),
		.dn_stall  (sample_stall),
		.dn_sample (sample)
	);

endmodule

FILE: rtl/pwg_checker.sv
// ----------------------------------------------------------------------------
// Periodic waveform generator checker
// Port-level assertions on the sample channel and back-pressure behavior.
// ----------------------------------------------------------------------------
`include "periodic_waveform_generator_assert.svh"

module pwg_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                time_stall,
	input logic                                sample_valid,
	input logic                                sample_stall,
	input logic signed [pwg_pkg::SAMPLE_W-1:0] sample
);

	`PWG_ASSERT(a_valid_hold, clk, arst_n, sample_valid && sample_stall |=> sample_valid, "sample_valid dropped while stalled")
	`PWG_ASSERT(a_sample_hold, clk, arst_n, sample_valid && sample_stall |=> $stable(sample), "sample changed while stalled")
	`PWG_ASSERT(a_no_min, clk, arst_n, sample_valid |-> sample != 16'sh8000, "sample out of range")
	`PWG_ASSERT(a_stall_cause, clk, arst_n, time_stall |-> sample_valid && sample_stall, "input stalled without output back-pressure")
	`PWG_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !sample_valid, "sample_valid high in reset")

endmodule

bind periodic_waveform_generator pwg_checker u_pwg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.time_stall   (time_stall),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.sample       (sample)
);
